>>> hw/rtl/rfr_pkg.sv
// Shared types, constants and helper functions of the radio frame receiver.
// Used by rfr_front, rfr_queue, rfr_back and radio_frame_receiver_unit.
`timescale 1ns / 1ps

package rfr_pkg;

    // Number of size classes that are searched.
    localparam int SIZE_CLASSES = 7;

    localparam logic [2:0] SIZE_UNKNOWN = 3'd7;

    localparam logic [7:0] PAD_MASK  = 8'h1F;
    localparam logic [7:0] FLAG_MASK = 8'hE0;

    // Result status codes.
    localparam logic [1:0] ST_PROGRESS = 2'd0;
    localparam logic [1:0] ST_REJECT   = 2'd1;
    localparam logic [1:0] ST_GOOD     = 2'd2;
    localparam logic [1:0] ST_BAD      = 2'd3;

    // Byte region codes.
    localparam logic [1:0] REG_TAG     = 2'd0;
    localparam logic [1:0] REG_HEADER  = 2'd1;
    localparam logic [1:0] REG_PAYLOAD = 2'd2;
    localparam logic [1:0] REG_TRAILER = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TAG_MAX_ERRORS = 2'd0;
    localparam logic [1:0] CFG_CRC_INITIAL    = 2'd1;
    localparam logic [1:0] CFG_CRC_FINAL_XOR  = 2'd2;
    localparam logic [1:0] CFG_CRC_REFLECTED  = 2'd3;

    // Queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_TAG0,
        PH_TAG1,
        PH_TAG2,
        PH_CODE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_TAG,
        KIND_MATCH,
        KIND_REJECT,
        KIND_CODE
    } t_kind;

    // One classified byte handed from the front to the back.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] rx_byte;
        logic [2:0] size_class;
        logic [7:0] byte_index;
        logic       last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [15:0] crc_initial;
        logic [15:0] crc_final_xor;
        logic        crc_reflected;
    } t_crc_cfg;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data_byte;
        logic [1:0] byte_region;
        logic [7:0] byte_index;
        logic [2:0] size_class;
        logic [7:0] payload_length;
        logic [2:0] frame_flags;
        logic       frame_end;
    } t_result;

    function automatic logic [23:0] f_size_tag(input logic [2:0] cls);
        logic [23:0] tag;
        case (cls)
            3'd0:    tag = 24'b001110110100100111001101;
            3'd1:    tag = 24'b010011011101101001010111;
            3'd2:    tag = 24'b011101101001001110011010;
            3'd3:    tag = 24'b100110111011010010101110;
            3'd4:    tag = 24'b101000001111110101100011;
            3'd5:    tag = 24'b110101100110111011111001;
            3'd6:    tag = 24'b111011010010011100110100;
            default: tag = 24'd0;
        endcase
        return tag;
    endfunction

    function automatic logic [7:0] f_capacity(input logic [2:0] cls);
        logic [7:0] cap;
        case (cls)
            3'd0:    cap = 8'd28;
            3'd1:    cap = 8'd60;
            3'd2:    cap = 8'd92;
            3'd3:    cap = 8'd124;
            3'd4:    cap = 8'd156;
            3'd5:    cap = 8'd188;
            default: cap = 8'd220;
        endcase
        return cap;
    endfunction

    function automatic logic [7:0] f_codeword(input logic [2:0] cls);
        logic [7:0] len;
        case (cls)
            3'd0:    len = 8'd47;
            3'd1:    len = 8'd79;
            3'd2:    len = 8'd111;
            3'd3:    len = 8'd159;
            3'd4:    len = 8'd191;
            3'd5:    len = 8'd223;
            default: len = 8'd255;
        endcase
        return len;
    endfunction

    // Eight steps of the scrambler LFSR: upper byte is the next window,
    // lower byte the sequence byte, first bit out in the MSB.
    function automatic logic [15:0] f_prn_step(input logic [7:0] win);
        logic [7:0] w;
        logic [7:0] seq;
        logic       fb;
        w   = win;
        seq = 8'd0;
        for (int i = 0; i < 8; i++) begin
            seq = {seq[6:0], w[7]};
            fb  = w[7] ^ w[4] ^ w[2] ^ w[0];
            w   = {w[6:0], fb};
        end
        return {w, seq};
    endfunction

    function automatic logic [15:0] f_crc_byte(input logic [15:0] c_in,
                                               input logic [7:0]  b,
                                               input logic        reflected);
        logic [15:0] c;
        c = c_in;
        if (reflected) begin
            c = c ^ {8'd0, b};
            for (int i = 0; i < 8; i++) begin
                c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
            end
        end else begin
            c = c ^ {b, 8'd0};
            for (int i = 0; i < 8; i++) begin
                c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
            end
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/rfr_front.sv
// Front end of the receiver: accepts bytes, tracks the frame phase, matches
// the size tag and classifies each byte for the back end. Uses rfr_pkg.
`timescale 1ns / 1ps

module rfr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_rx_byte,
    input  logic [4:0]          i_tag_max_errors,
    input  rfr_pkg::t_q_status  i_q_status,
    output logic                o_push,
    output rfr_pkg::t_entry     o_entry
);

    rfr_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_tag_bytes, n_tag_bytes;
    logic [2:0]  r_size_sel, n_size_sel;
    logic [7:0]  r_byte_count, n_byte_count;

    logic        accept;
    logic        hit;
    logic [2:0]  hit_class;
    logic [23:0] full_tag;
    logic [8:0]  count_next;

    assign o_ready    = !i_q_status.full;
    assign accept     = i_valid && o_ready;
    assign full_tag   = {r_tag_bytes, i_rx_byte};
    assign count_next = {1'b0, r_byte_count} + 9'd1;

    // Walk the classes from the last down, so the lowest matching one wins.
    always_comb begin
        logic [4:0] ham_dist;
        hit       = 1'b0;
        hit_class = rfr_pkg::SIZE_UNKNOWN;
        for (int i = rfr_pkg::SIZE_CLASSES - 1; i >= 0; i--) begin
            ham_dist = 5'($countones(full_tag ^ rfr_pkg::f_size_tag(3'(i))));
            if (ham_dist <= i_tag_max_errors) begin
                hit       = 1'b1;
                hit_class = 3'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rfr_pkg::PH_TAG0;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_bytes  <= 16'd0;
            r_size_sel   <= rfr_pkg::SIZE_UNKNOWN;
            r_byte_count <= 8'd0;
        end else begin
            r_tag_bytes  <= n_tag_bytes;
            r_size_sel   <= n_size_sel;
            r_byte_count <= n_byte_count;
        end
    end

    always_comb begin
        n_phase            = r_phase;
        n_tag_bytes        = r_tag_bytes;
        n_size_sel         = r_size_sel;
        n_byte_count       = r_byte_count;
        o_push             = accept;
        o_entry.kind       = rfr_pkg::KIND_TAG;
        o_entry.rx_byte    = i_rx_byte;
        o_entry.size_class = rfr_pkg::SIZE_UNKNOWN;
        o_entry.byte_index = 8'd0;
        o_entry.last       = 1'b0;
        case (r_phase)
            rfr_pkg::PH_TAG0: begin
                if (accept) begin
                    n_tag_bytes = {8'd0, i_rx_byte};
                    n_size_sel  = rfr_pkg::SIZE_UNKNOWN;
                    n_phase     = rfr_pkg::PH_TAG1;
                end
            end
            rfr_pkg::PH_TAG1: begin
                if (accept) begin
                    n_tag_bytes = {r_tag_bytes[7:0], i_rx_byte};
                    n_phase     = rfr_pkg::PH_TAG2;
                end
            end
            rfr_pkg::PH_TAG2: begin
                o_entry.kind       = hit ? rfr_pkg::KIND_MATCH : rfr_pkg::KIND_REJECT;
                o_entry.size_class = hit_class;
                o_entry.last       = !hit;
                if (accept) begin
                    n_size_sel   = hit_class;
                    n_byte_count = 8'd0;
                    n_phase      = hit ? rfr_pkg::PH_CODE : rfr_pkg::PH_TAG0;
                end
            end
            rfr_pkg::PH_CODE: begin
                o_entry.kind       = rfr_pkg::KIND_CODE;
                o_entry.size_class = r_size_sel;
                o_entry.byte_index = r_byte_count;
                o_entry.last       = count_next >= {1'b0, rfr_pkg::f_codeword(r_size_sel)};
                if (accept) begin
                    if (o_entry.last) begin
                        n_phase = rfr_pkg::PH_TAG0;
                    end else begin
                        n_byte_count = count_next[7:0];
                    end
                end
            end
            default: begin
                n_phase = rfr_pkg::PH_TAG0;
            end
        endcase
    end

endmodule

>>> hw/rtl/rfr_queue.sv
// Short first-in first-out queue of classified bytes between front and back.
// Uses rfr_pkg for the entry type and depth.
`timescale 1ns / 1ps

module rfr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rfr_pkg::t_entry     i_entry,
    input  logic                i_pop,
    output rfr_pkg::t_entry     o_entry,
    output rfr_pkg::t_q_status  o_status
);

    rfr_pkg::t_entry r_mem [rfr_pkg::Q_DEPTH];

    logic [rfr_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [rfr_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [rfr_pkg::Q_CNT_W-1:0] r_count;

    assign o_status.full  = (r_count == rfr_pkg::Q_CNT_W'(rfr_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_entry        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/rfr_back.sv
// Back end of the receiver: descrambles codeword bytes, decodes the header,
// runs the CRC check and holds the result register. Uses rfr_pkg.
`timescale 1ns / 1ps

module rfr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rfr_pkg::t_entry     i_entry,
    input  rfr_pkg::t_q_status  i_q_status,
    input  rfr_pkg::t_crc_cfg   i_crc_cfg,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output rfr_pkg::t_result    o_result
);

    logic [7:0]  r_payload_len, n_payload_len;
    logic [2:0]  r_flags, n_flags;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_high, n_crc_high;
    logic [7:0]  r_lfsr, n_lfsr;
    logic        r_length_bad, n_length_bad;
    logic        r_crc_ok, n_crc_ok;

    logic             r_out_valid;
    rfr_pkg::t_result r_result, n_result;

    logic [15:0] prn;
    logic [7:0]  plain;
    logic [4:0]  pad;
    logic [7:0]  cap;
    logic [8:0]  idx_ext;
    logic [8:0]  len_ext;

    assign o_pop    = !i_q_status.empty && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    assign prn     = rfr_pkg::f_prn_step(r_lfsr);
    assign plain   = i_entry.rx_byte ^ prn[7:0];
    assign pad     = plain[4:0];
    assign cap     = rfr_pkg::f_capacity(i_entry.size_class);
    assign idx_ext = {1'b0, i_entry.byte_index};
    assign len_ext = {1'b0, r_payload_len};

    always_comb begin
        n_payload_len = r_payload_len;
        n_flags       = r_flags;
        n_crc         = r_crc;
        n_crc_high    = r_crc_high;
        n_lfsr        = r_lfsr;
        n_length_bad  = r_length_bad;
        n_crc_ok      = r_crc_ok;

        n_result.status         = rfr_pkg::ST_PROGRESS;
        n_result.data_byte      = 8'd0;
        n_result.byte_region    = rfr_pkg::REG_TAG;
        n_result.byte_index     = 8'd0;
        n_result.size_class     = rfr_pkg::SIZE_UNKNOWN;
        n_result.payload_length = 8'd0;
        n_result.frame_flags    = 3'd0;
        n_result.frame_end      = 1'b0;

        case (i_entry.kind)
            rfr_pkg::KIND_TAG: begin
                n_payload_len = 8'd0;
                n_flags       = 3'd0;
            end
            rfr_pkg::KIND_REJECT: begin
                n_result.status    = rfr_pkg::ST_REJECT;
                n_result.frame_end = 1'b1;
            end
            rfr_pkg::KIND_MATCH: begin
                n_payload_len       = 8'd0;
                n_flags             = 3'd0;
                n_crc               = i_crc_cfg.crc_initial;
                n_crc_high          = 8'd0;
                n_lfsr              = 8'hFF;
                n_length_bad        = 1'b0;
                n_crc_ok            = 1'b0;
                n_result.size_class = i_entry.size_class;
            end
            rfr_pkg::KIND_CODE: begin
                n_lfsr               = prn[15:8];
                n_result.data_byte   = plain;
                n_result.byte_index  = i_entry.byte_index;
                n_result.size_class  = i_entry.size_class;
                if (i_entry.byte_index == 8'd0) begin
                    n_result.byte_region = rfr_pkg::REG_HEADER;
                    n_flags = 3'((plain & rfr_pkg::FLAG_MASK) >> 5);
                    if ({3'd0, pad} > cap) begin
                        n_length_bad  = 1'b1;
                        n_payload_len = 8'd0;
                    end else begin
                        n_payload_len = cap - {3'd0, pad};
                    end
                    n_crc = rfr_pkg::f_crc_byte(r_crc, plain, i_crc_cfg.crc_reflected);
                end else if (!r_length_bad && i_entry.byte_index <= r_payload_len) begin
                    n_result.byte_region = rfr_pkg::REG_PAYLOAD;
                    n_crc = rfr_pkg::f_crc_byte(r_crc, plain, i_crc_cfg.crc_reflected);
                end else begin
                    n_result.byte_region = rfr_pkg::REG_TRAILER;
                    if (!r_length_bad && idx_ext == len_ext + 9'd1) begin
                        n_crc_high = plain;
                    end else if (!r_length_bad && idx_ext == len_ext + 9'd2) begin
                        n_crc_ok = ((r_crc ^ i_crc_cfg.crc_final_xor) == {r_crc_high, plain});
                    end
                end
                n_result.payload_length = n_payload_len;
                n_result.frame_flags    = n_flags;
                if (i_entry.last) begin
                    n_result.frame_end = 1'b1;
                    n_result.status    = (!n_length_bad && n_crc_ok) ? rfr_pkg::ST_GOOD
                                                                     : rfr_pkg::ST_BAD;
                end
            end
            default: begin
                n_result.status = rfr_pkg::ST_PROGRESS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_len <= 8'd0;
            r_flags       <= 3'd0;
            r_crc         <= 16'd0;
            r_crc_high    <= 8'd0;
            r_lfsr        <= 8'hFF;
            r_length_bad  <= 1'b0;
            r_crc_ok      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_payload_len <= n_payload_len;
                r_flags       <= n_flags;
                r_crc         <= n_crc;
                r_crc_high    <= n_crc_high;
                r_lfsr        <= n_lfsr;
                r_length_bad  <= n_length_bad;
                r_crc_ok      <= n_crc_ok;
                r_out_valid   <= 1'b1;
            end else if (i_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

endmodule

>>> hw/rtl/radio_frame_receiver_unit.sv
// Top level of the radio frame receiver: configuration registers and the
// front end, queue and back end. Depends on rfr_pkg, rfr_front, rfr_queue, rfr_back.
`timescale 1ns / 1ps

// Channel        | Handshake                   | Payload
// ---------------+-----------------------------+------------------------------------
// byte in        | i_valid / o_ready           | i_rx_byte
// result out     | o_valid / i_ready           | o_status .. o_frame_end (8 fields)
// configuration  | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// Every accepted byte gives exactly one result request. The block sustains one
// byte per cycle while the output is not stalled; the front end is combinational,
// so a byte is written into the queue at the edge that accepts it and reaches the
// output register when the back end pops it.
// Reset is synchronous and active low; it restores the register defaults and
// empties the queue, with no clearing pass. A stall on the output fills the
// four-entry queue, after which o_ready drops until the back end pops an entry.

module radio_frame_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    // result output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_data_byte,
    output logic [1:0]  o_byte_region,
    output logic [7:0]  o_byte_index,
    output logic [2:0]  o_size_class,
    output logic [7:0]  o_payload_length,
    output logic [2:0]  o_frame_flags,
    output logic        o_frame_end,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Configuration registers. Writes are always taken; the user must write only
    // while the receiver is idle (the block does not enforce it), so no shadowing is needed.
    logic [4:0]  r_tag_max_errors;
    logic [15:0] r_crc_initial;
    logic [15:0] r_crc_final_xor;
    logic        r_crc_reflected;

    logic cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_max_errors <= 5'd6;
            r_crc_initial    <= 16'hFFFF;
            r_crc_final_xor  <= 16'hFFFF;
            r_crc_reflected  <= 1'b1;
        end else if (cfg_write) begin
            case (i_cfg_index)
                rfr_pkg::CFG_TAG_MAX_ERRORS: r_tag_max_errors <= i_cfg_data[4:0];
                rfr_pkg::CFG_CRC_INITIAL:    r_crc_initial    <= i_cfg_data;
                rfr_pkg::CFG_CRC_FINAL_XOR:  r_crc_final_xor  <= i_cfg_data;
                rfr_pkg::CFG_CRC_REFLECTED:  r_crc_reflected  <= i_cfg_data[0];
                default: begin
                    r_crc_reflected <= r_crc_reflected;
                end
            endcase
        end
    end

    rfr_pkg::t_crc_cfg crc_cfg;

    assign crc_cfg.crc_initial   = r_crc_initial;
    assign crc_cfg.crc_final_xor = r_crc_final_xor;
    assign crc_cfg.crc_reflected = r_crc_reflected;

    // Front end: phase tracking and size tag match. It classifies every byte
    // as tag byte, tag match, tag reject or codeword byte and queues it.
    rfr_pkg::t_q_status q_status;
    rfr_pkg::t_entry    push_entry;
    rfr_pkg::t_entry    head_entry;
    logic               q_push;
    logic               q_pop;

    rfr_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_rx_byte        (i_rx_byte),
        .i_tag_max_errors (r_tag_max_errors),
        .i_q_status       (q_status),
        .o_push           (q_push),
        .o_entry          (push_entry)
    );

    // The queue lets the front keep taking bytes while the output stalls.
    rfr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (push_entry),
        .i_pop    (q_pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    // Back end: descrambler, header decode, CRC and the output register.
    rfr_pkg::t_result result;

    rfr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (head_entry),
        .i_q_status (q_status),
        .i_crc_cfg  (crc_cfg),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (result)
    );

    assign o_status         = result.status;
    assign o_data_byte      = result.data_byte;
    assign o_byte_region    = result.byte_region;
    assign o_byte_index     = result.byte_index;
    assign o_size_class     = result.size_class;
    assign o_payload_length = result.payload_length;
    assign o_frame_flags    = result.frame_flags;
    assign o_frame_end      = result.frame_end;

`ifndef ASSERT_OFF
    // The front must never push into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("queue overflow");

    // The back must never pop an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue underflow");

    // A final status appears exactly on the byte that ends a frame.
    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_end == (o_status != rfr_pkg::ST_PROGRESS)))
        else $error("frame end and status disagree");

    // Codeword bytes always carry a known size class.
    a_class_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_region != rfr_pkg::REG_TAG)
            |-> o_size_class != rfr_pkg::SIZE_UNKNOWN)
        else $error("codeword byte without size class");
`endif

endmodule

>>> bench/radio_frame_receiver_unit_test.sv
// Self-checking bench for radio_frame_receiver_unit: builds scrambled size-tagged
// frames, decodes every accepted byte in a bit-exact software decoder and compares.
// Depends on rfr_pkg and the radio_frame_receiver_unit RTL.
`timescale 1ns / 1ps

import rfr_pkg::*;

// Software copy of the frame decoder plus the queue of decoded bytes that
// the block still owes us.
class frame_tracker;

    logic [4:0]  tag_max_errors;
    logic [15:0] crc_initial;
    logic [15:0] crc_final_xor;
    logic        crc_reflected;

    t_phase      phase;
    logic [15:0] tag_hist;
    logic [2:0]  size_sel;
    logic [7:0]  byte_count;
    logic [7:0]  payload_len;
    logic [2:0]  flags_held;
    logic [15:0] crc_reg;
    logic [7:0]  crc_high;
    logic [7:0]  lfsr;
    logic        length_bad;
    logic        crc_ok;

    t_result     decoded_q[$];
    int          mismatches;

    function new();
        tag_max_errors = 5'd6;
        crc_initial    = 16'hFFFF;
        crc_final_xor  = 16'hFFFF;
        crc_reflected  = 1'b1;
        phase          = PH_TAG0;
        tag_hist       = '0;
        size_sel       = SIZE_UNKNOWN;
        byte_count     = '0;
        payload_len    = '0;
        flags_held     = '0;
        crc_reg        = '0;
        crc_high       = '0;
        lfsr           = 8'hFF;
        length_bad     = 1'b0;
        crc_ok         = 1'b0;
        mismatches     = 0;
    endfunction

    static function logic [23:0] size_tag_of(int cls);
        logic [23:0] tags [7];
        tags = '{24'h3B49CD, 24'h4DDA57, 24'h76939A, 24'h9BB4AE,
                 24'hA0FD63, 24'hD66EF9, 24'hED2734};
        return tags[cls];
    endfunction

    // Capacity grows by 32 bytes per class; the codeword adds header, CRC
    // and 16 or 32 parity bytes on top.
    static function logic [7:0] capacity_of(int cls);
        return 8'(28 + 32 * cls);
    endfunction

    static function int codeword_len_of(int cls);
        return int'(capacity_of(cls)) + ((cls < 3) ? 19 : 35);
    endfunction

    static function logic [2:0] match_size_class(logic [23:0] tag, logic [4:0] thr);
        for (int i = 0; i < SIZE_CLASSES; i++) begin
            if ($countones(tag ^ size_tag_of(i)) <= int'(thr)) begin
                return 3'(i);
            end
        end
        return SIZE_UNKNOWN;
    endfunction

    // Returns {next window, sequence byte}; the first bit out lands in the MSB.
    static function logic [15:0] prn_step(logic [7:0] w_in);
        logic [7:0] w;
        logic [7:0] s;
        w = w_in;
        s = 8'h00;
        repeat (8) begin
            s = {s[6:0], w[7]};
            w = {w[6:0], ^(w & 8'b1001_0101)};
        end
        return {w, s};
    endfunction

    static function logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b, logic refl);
        logic [15:0] r;
        r = c;
        if (refl) begin
            r = r ^ {8'h00, b};
            repeat (8) r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
        end else begin
            r = r ^ {b, 8'h00};
            repeat (8) r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
        end
        return r;
    endfunction

    static function string describe(t_result r);
        return $sformatf({"status %0d data %02h region %0d index %0d class %0d",
                          " len %0d flags %0d end %0b"},
                         r.status, r.data_byte, r.byte_region, r.byte_index,
                         r.size_class, r.payload_length, r.frame_flags, r.frame_end);
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] val);
        case (idx)
            CFG_TAG_MAX_ERRORS: tag_max_errors = val[4:0];
            CFG_CRC_INITIAL:    crc_initial    = val;
            CFG_CRC_FINAL_XOR:  crc_final_xor  = val;
            CFG_CRC_REFLECTED:  crc_reflected  = val[0];
            default: ;
        endcase
    endfunction

    // Advances the decoder by one received byte and queues what the block
    // must report for it.
    function void decode_rx_byte(logic [7:0] d);
        t_result    r;
        logic [15:0] win_seq;
        logic [7:0] b;
        logic [7:0] k;
        logic [7:0] cap;
        logic [7:0] pad;
        int         cw_len;
        r = '0;
        r.status      = ST_PROGRESS;
        r.byte_region = REG_TAG;
        case (phase)
            PH_TAG0, PH_TAG1: begin
                tag_hist    = (phase == PH_TAG0) ? {8'h00, d} : {tag_hist[7:0], d};
                size_sel    = SIZE_UNKNOWN;
                payload_len = '0;
                flags_held  = '0;
                phase       = (phase == PH_TAG0) ? PH_TAG1 : PH_TAG2;
            end
            PH_TAG2: begin
                size_sel = match_size_class({tag_hist, d}, tag_max_errors);
                if (size_sel == SIZE_UNKNOWN) begin
                    r.status    = ST_REJECT;
                    r.frame_end = 1'b1;
                    phase       = PH_TAG0;
                end else begin
                    phase       = PH_CODE;
                    byte_count  = '0;
                    payload_len = '0;
                    flags_held  = '0;
                    crc_reg     = crc_initial;
                    crc_high    = '0;
                    lfsr        = 8'hFF;
                    length_bad  = 1'b0;
                    crc_ok      = 1'b0;
                end
            end
            default: begin
                win_seq = prn_step(lfsr);
                lfsr    = win_seq[15:8];
                b       = d ^ win_seq[7:0];
                k       = byte_count;
                cap     = capacity_of(int'(size_sel));
                cw_len  = codeword_len_of(int'(size_sel));
                r.data_byte  = b;
                r.byte_index = k;
                if (k == 8'd0) begin
                    r.byte_region = REG_HEADER;
                    pad           = b & PAD_MASK;
                    flags_held    = 3'((b & FLAG_MASK) >> 5);
                    if (pad > cap) begin
                        length_bad  = 1'b1;
                        payload_len = '0;
                    end else begin
                        payload_len = cap - pad;
                    end
                    crc_reg = crc16_update(crc_reg, b, crc_reflected);
                end else if (!length_bad && k <= payload_len) begin
                    r.byte_region = REG_PAYLOAD;
                    crc_reg = crc16_update(crc_reg, b, crc_reflected);
                end else begin
                    r.byte_region = REG_TRAILER;
                    if (!length_bad && int'(k) == int'(payload_len) + 1) begin
                        crc_high = b;
                    end else if (!length_bad && int'(k) == int'(payload_len) + 2) begin
                        crc_ok = ((crc_reg ^ crc_final_xor) == {crc_high, b});
                    end
                end
                if (int'(k) + 1 >= cw_len) begin
                    r.frame_end = 1'b1;
                    r.status    = (!length_bad && crc_ok) ? ST_GOOD : ST_BAD;
                    phase       = PH_TAG0;
                end else begin
                    byte_count = k + 8'd1;
                end
            end
        endcase
        r.size_class     = size_sel;
        r.payload_length = payload_len;
        r.frame_flags    = flags_held;
        decoded_q.push_back(r);
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (decoded_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result with nothing pending at %0t: %s", $time, describe(got));
            end
            return;
        end
        want = decoded_q.pop_front();
        if (got.status !== want.status || got.data_byte !== want.data_byte ||
            got.byte_region !== want.byte_region || got.byte_index !== want.byte_index ||
            got.size_class !== want.size_class || got.payload_length !== want.payload_length ||
            got.frame_flags !== want.frame_flags || got.frame_end !== want.frame_end) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch at %0t", $time);
                $display("  expected %s", describe(want));
                $display("  actual   %s", describe(got));
            end
        end
    endfunction

    function int pending();
        return decoded_q.size();
    endfunction

endclass

module radio_frame_receiver_unit_test;

    // The slowest legal run stays far below this; it only catches a hang.
    localparam int CYCLE_LIMIT   = 200000;
    // Quiet cycles after the last result, to catch anything extra the block
    // might still emit (the four-entry queue and the output register).
    localparam int SETTLE_CYCLES = 16;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [7:0]  i_rx_byte   = '0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_data_byte;
    logic [1:0]  o_byte_region;
    logic [7:0]  o_byte_index;
    logic [2:0]  o_size_class;
    logic [7:0]  o_payload_length;
    logic [2:0]  o_frame_flags;
    logic        o_frame_end;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;

    frame_tracker tracker = new();

    // Settings currently in the block, as seen by the frame generator.
    logic [4:0]  cur_thr;
    logic [15:0] cur_init;
    logic [15:0] cur_fx;
    logic        cur_refl;

    // Percent of cycles in which the byte sender and the result receiver idle.
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          items_sent    = 0;
    int          cycles;
    logic [7:0]  frame_bytes[$];
    t_result     observed;

    radio_frame_receiver_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_data_byte      (o_data_byte),
        .o_byte_region    (o_byte_region),
        .o_byte_index     (o_byte_index),
        .o_size_class     (o_size_class),
        .o_payload_length (o_payload_length),
        .o_frame_flags    (o_frame_flags),
        .o_frame_end      (o_frame_end),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side. Outputs are sampled at the edge, before this edge's updates
    // land, so every accepted result request is seen with its own payload.
    // i_ready is redrawn every cycle to stall the block at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            observed = {o_status, o_data_byte, o_byte_region, o_byte_index,
                        o_size_class, o_payload_length, o_frame_flags, o_frame_end};
            tracker.check_result(observed);
        end
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offers one byte, possibly after some idle cycles, and holds it until the
    // block takes the request. The decoder is advanced at the accepting edge.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tracker.decode_rx_byte(b);
        items_sent++;
    endtask

    task automatic send_frame_bytes(input int from, input int upto);
        for (int i = from; i < upto; i++) begin
            send_byte(frame_bytes[i]);
        end
    endtask

    // Stops sending and waits until the block has delivered every result it
    // owes. Always waits on the clock first, so i_valid is never assigned
    // twice in one step.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.set_register(idx, val);
    endtask

    // Register writes only happen with nothing in flight. The frame state of
    // the block is left alone, so a write may land in the middle of a frame.
    task automatic configure(input logic [4:0] thr, input logic [15:0] init,
                             input logic [15:0] fx, input logic refl);
        wait_drained();
        write_register(CFG_TAG_MAX_ERRORS, {11'd0, thr});
        write_register(CFG_CRC_INITIAL, init);
        write_register(CFG_CRC_FINAL_XOR, fx);
        write_register(CFG_CRC_REFLECTED, {15'd0, refl});
        i_cfg_valid <= 1'b0;
        cur_thr  = thr;
        cur_init = init;
        cur_fx   = fx;
        cur_refl = refl;
    endtask

    // Builds the on-air bytes of one frame: the three tag bytes and, when the
    // tag will match under the current threshold, the scrambled codeword of
    // the class that the block will pick. The CRC is computed with the
    // current settings; crc_bad flips one of its bits, noise replaces the
    // whole codeword by random bytes.
    task automatic build_frame(input logic [23:0] tag, input logic [4:0] pad,
                               input logic [2:0] flags, input bit crc_bad, input bit noise);
        logic [2:0]  cls;
        logic [7:0]  plain[$];
        logic [15:0] crc;
        logic [15:0] win_seq;
        logic [7:0]  cap;
        logic [7:0]  w;
        int          len;
        int          plen;
        frame_bytes.delete();
        frame_bytes.push_back(tag[23:16]);
        frame_bytes.push_back(tag[15:8]);
        frame_bytes.push_back(tag[7:0]);
        cls = tracker.match_size_class(tag, cur_thr);
        if (cls == SIZE_UNKNOWN) begin
            return;
        end
        cap = tracker.capacity_of(int'(cls));
        len = tracker.codeword_len_of(int'(cls));
        plain.push_back({flags, pad});
        // With the padding above the capacity the block skips the CRC, so
        // the rest is just filler.
        if ({3'd0, pad} <= cap) begin
            plen = int'(cap) - int'(pad);
            crc  = tracker.crc16_update(cur_init, plain[0], cur_refl);
            for (int i = 0; i < plen; i++) begin
                plain.push_back(8'($urandom()));
                crc = tracker.crc16_update(crc, plain[plain.size() - 1], cur_refl);
            end
            crc = crc ^ cur_fx;
            if (crc_bad) begin
                crc = crc ^ (16'h0001 << $urandom_range(15));
            end
            plain.push_back(crc[15:8]);
            plain.push_back(crc[7:0]);
        end
        while (plain.size() < len) plain.push_back(8'($urandom()));
        w = 8'hFF;
        for (int i = 0; i < len; i++) begin
            win_seq = tracker.prn_step(w);
            w       = win_seq[15:8];
            frame_bytes.push_back(noise ? 8'($urandom()) : (plain[i] ^ win_seq[7:0]));
        end
    endtask

    // Mostly well-formed frames with random content, small classes favored.
    // The rest are random tags, tags with too many bit errors, bad CRCs,
    // oversized padding and noise codewords.
    task automatic send_random_frame();
        int          kind;
        int          pick;
        int          cls;
        int          errs;
        logic [23:0] flips;
        logic [4:0]  pad;
        kind = $urandom_range(99);
        pick = $urandom_range(99);
        cls  = (pick < 70) ? 0 : (pick < 88) ? 1 : (pick < 95) ? $urandom_range(5, 2) : 6;
        if (kind < 10) begin
            build_frame(24'($urandom()), 5'($urandom()), 3'($urandom()), 1'b0, kind < 5);
        end else begin
            if (kind < 20) begin
                errs = int'(cur_thr) + $urandom_range(4, 1);
            end else begin
                errs = $urandom_range((cur_thr < 5'd3) ? int'(cur_thr) : 3, 0);
            end
            if (errs > 24) begin
                errs = 24;
            end
            flips = '0;
            while ($countones(flips) < errs) flips[$urandom_range(23)] = 1'b1;
            case ($urandom_range(9))
                0, 1:    pad = 5'd0;
                2:       pad = 5'd31;
                3:       pad = 5'd28;
                4:       pad = 5'd29;
                default: pad = 5'($urandom());
            endcase
            build_frame(tracker.size_tag_of(cls) ^ flips, pad, 3'($urandom()),
                        (kind >= 20 && kind < 35), 1'b0);
        end
        send_frame_bytes(0, frame_bytes.size());
    endtask

    task automatic run_phase(input logic [4:0] thr, input logic [15:0] init,
                             input logic [15:0] fx, input logic refl,
                             input int s_idle, input int r_idle, input int n_items);
        int target;
        configure(thr, init, fx, refl);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        target = items_sent + n_items;
        while (items_sent < target) begin
            send_random_frame();
            // Now and then the sender holds off until the block is empty.
            if ($urandom_range(24) == 0) begin
                wait_drained();
            end
        end
    endtask

    // Hang guard.
    initial begin
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under the reset settings, written explicitly:
        // all-zero and all-one tags, which are rejected, a frame whose
        // padding exceeds the capacity, and a good frame with no padding.
        send_idle_pct = 7;
        recv_idle_pct = 70;
        configure(5'd6, 16'hFFFF, 16'hFFFF, 1'b1);
        build_frame(24'h000000, 5'd0, 3'd0, 1'b0, 1'b0);
        send_frame_bytes(0, frame_bytes.size());
        build_frame(24'hFFFFFF, 5'd0, 3'd0, 1'b0, 1'b0);
        send_frame_bytes(0, frame_bytes.size());
        build_frame(tracker.size_tag_of(0), 5'd31, 3'd7, 1'b0, 1'b0);
        send_frame_bytes(0, frame_bytes.size());
        build_frame(tracker.size_tag_of(0) ^ 24'h800001, 5'd0, 3'd5, 1'b0, 1'b0);
        send_frame_bytes(0, frame_bytes.size());

        // Random traffic: receiver stalls heavily first, then the sender,
        // then neither. The settings walk through the extremes.
        run_phase(5'd6, 16'hFFFF, 16'hFFFF, 1'b1, 7, 70, 140);
        run_phase(5'd0, 16'h0000, 16'h0000, 1'b0, 7, 70, 150);
        // Threshold at the tag width: every tag lands in the smallest class.
        run_phase(5'd24, 16'($urandom()), 16'($urandom()), 1'b1, 70, 7, 150);

        // Change the CRC settings mid-frame: the block uses the new
        // reflection and XOR where next used, the initial value in the next frame.
        build_frame(tracker.size_tag_of(1), 5'd10, 3'd2, 1'b0, 1'b0);
        send_frame_bytes(0, 20);
        configure(5'($urandom_range(12, 1)), 16'($urandom()), 16'hFFFF, 1'b0);
        send_frame_bytes(20, frame_bytes.size());

        run_phase(cur_thr, cur_init, 16'hFFFF, 1'b0, 70, 7, 150);
        run_phase(5'd6, 16'hFFFF, 16'h0000, 1'b1, 0, 0, 150);
        run_phase(5'($urandom_range(24)), 16'($urandom()), 16'($urandom()),
                  1'($urandom()), 0, 0, 120);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
